/* src/image_part_reassembly_with_history_core_defines.svh */
// Assertion macros for the image part reassembly core.
// Sampled on clk_i, disabled while rst_ni is low.
`ifndef IMAGE_PART_REASSEMBLY_WITH_HISTORY_CORE_DEFINES_SVH
`define IMAGE_PART_REASSEMBLY_WITH_HISTORY_CORE_DEFINES_SVH

`define IPRH_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iprh assertion failed");

`define IPRH_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("iprh forbidden condition");

`endif

/* src/iprh_pkg.sv */
// Shared word types and codes for the image part reassembly core.
// No dependencies.
package iprh_pkg;

  typedef struct packed {
    logic       operation;
    logic [15:0] image_number;
    logic [3:0] part_index;
    logic [6:0] byte_offset;
    logic [7:0] byte_value;
    logic       part_end;
    logic [3:0] read_slot;
    logic [4:0] read_row;
    logic [4:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_value;
    logic [3:0] frames_stored;
    logic [3:0] newest_slot;
    logic [7:0] parts_mask;
  } out_word_t;

  typedef struct packed {
    logic part_ok;
    logic byte_ok;
    logic slot_ok;
    logic in_frame;
  } dec_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_BAD_PART = 2'd2;
  localparam logic [1:0] ST_BAD_SLOT = 2'd3;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;

endpackage

/* src/iprh_decode.sv */
// Word decoder: part and slot checks, assembly and pixel addresses.
// Depends on iprh_pkg.
module iprh_decode #(
  parameter int unsigned FRAME_PIXELS  = 1024,
  parameter int unsigned PART_COUNT    = 8,
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned FRAME_SIDE    = 32,
  localparam int unsigned PW = $clog2(FRAME_PIXELS)
) (
  input  iprh_pkg::in_word_t     word_i,
  output iprh_pkg::dec_t         dec_o,
  output logic [PW-1:0]          store_addr_o,
  output logic [PW-1:0]          pix_addr_o,
  output logic [PART_COUNT-1:0]  part_sel_o
);
  import iprh_pkg::*;

  localparam int unsigned PART_BYTES = FRAME_PIXELS / PART_COUNT;
  localparam int unsigned SPW        = PW + 5;
  localparam int unsigned SIDE_W     = $clog2(FRAME_SIDE + 1);
  localparam int unsigned PPW        = PW + SIDE_W + 6;

  logic [3:0]     part_m1;
  logic [SPW-1:0] spos;
  logic [PPW-1:0] ppos;

  always_comb begin
    part_m1 = word_i.part_index - 4'd1;
    spos = SPW'(part_m1) * SPW'(PART_BYTES) + SPW'(word_i.byte_offset);
    ppos = PPW'(word_i.read_row) * PPW'(FRAME_SIDE) + PPW'(word_i.read_col);

    dec_o.part_ok = (word_i.part_index != 4'd0) &&
                    (32'(word_i.part_index) <= PART_COUNT);
    dec_o.byte_ok = dec_o.part_ok && (word_i.byte_value != 8'd0) &&
                    (32'(word_i.byte_offset) < PART_BYTES) &&
                    (32'(spos) < FRAME_PIXELS);
    dec_o.slot_ok = 32'(word_i.read_slot) < HISTORY_DEPTH;
    dec_o.in_frame = (32'(word_i.read_row) < FRAME_SIDE) &&
                     (32'(word_i.read_col) < FRAME_SIDE) &&
                     (32'(ppos) < FRAME_PIXELS);

    store_addr_o = spos[PW-1:0];
    pix_addr_o   = ppos[PW-1:0];
    part_sel_o   = dec_o.part_ok ? (PART_COUNT'(1) << part_m1) : '0;
  end

endmodule

/* src/image_part_reassembly_with_history_core.sv */
// Image part reassembly core: assembly buffer plus frame history ring in two memories.
// A write word is applied from S_IDLE; a pixel read passes through S_READ; a completing word enters S_COMMIT,
// which walks the assembly memory's read port one entry per cycle, copying each entry into the ring and clearing it.
// A new image over a dirty buffer first clears it in S_CLEAR.
// After reset a clearing pass over the assembly memory runs before the first word is taken.
// Depends on iprh_pkg, iprh_decode and the defines header.
`include "image_part_reassembly_with_history_core_defines.svh"

module image_part_reassembly_with_history_core #(
  parameter int unsigned FRAME_PIXELS  = 1024,
  parameter int unsigned PART_COUNT    = 8,
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned FRAME_SIDE    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iprh_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iprh_pkg::out_word_t out_word_o
);
  import iprh_pkg::*;

  localparam int unsigned PW         = $clog2(FRAME_PIXELS);
  localparam int unsigned SW         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW         = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HIST_DEPTH = HISTORY_DEPTH << PW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_APPLY,
    S_COMMIT,
    S_READ
  } state_e;

  state_e                state_q, state_d;
  logic [PW-1:0]         cnt_q, cnt_d;
  logic                  rd_v_q, rd_v_d;
  logic [PW-1:0]         rd_a_q, rd_a_d;
  logic                  ended_q, ended_d;
  logic                  pend_q, pend_d;
  in_word_t              item_q, item_d;
  logic [PART_COUNT-1:0] mask_q, mask_d;
  logic [15:0]           cur_q, cur_d;
  logic                  active_q, active_d;
  logic                  clean_q, clean_d;
  logic [SW-1:0]         wslot_q, wslot_d;
  logic [FW-1:0]         filled_q, filled_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  logic [7:0]      asm_mem [FRAME_PIXELS];
  logic            asm_we;
  logic [PW-1:0]   asm_wa, asm_ra;
  logic [7:0]      asm_wd, asm_rd_q;

  logic [7:0]      hist_mem [HIST_DEPTH];
  logic            hist_we;
  logic [SW+PW-1:0] hist_wa, hist_ra;
  logic [7:0]      hist_wd, hist_rd_q;

  in_word_t              sel;
  dec_t                  dec;
  logic [PW-1:0]         store_addr, pix_addr;
  logic [PART_COUNT-1:0] part_sel;

  logic                  out_free, new_img, do_apply, load_res, ended_now;
  logic [PART_COUNT-1:0] mask_new;
  logic [1:0]            res_status;
  logic [7:0]            res_pixel;

  assign sel = (state_q == S_APPLY) ? item_q : in_word_i;

  iprh_decode #(
    .FRAME_PIXELS  (FRAME_PIXELS),
    .PART_COUNT    (PART_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .FRAME_SIDE    (FRAME_SIDE)
  ) u_decode (
    .word_i       (sel),
    .dec_o        (dec),
    .store_addr_o (store_addr),
    .pix_addr_o   (pix_addr),
    .part_sel_o   (part_sel)
  );

  always_ff @(posedge clk_i) begin
    if (asm_we) begin
      asm_mem[asm_wa] <= asm_wd;
    end
    asm_rd_q <= asm_mem[asm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_v_d      = rd_v_q;
    rd_a_d      = rd_a_q;
    ended_d     = ended_q;
    pend_d      = pend_q;
    item_d      = item_q;
    mask_d      = mask_q;
    cur_d       = cur_q;
    active_d    = active_q;
    clean_d     = clean_q;
    wslot_d     = wslot_q;
    filled_d    = filled_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    asm_we    = 1'b0;
    asm_wa    = cnt_q;
    asm_wd    = 8'd0;
    asm_ra    = cnt_q;
    hist_we   = 1'b0;
    hist_wa   = {wslot_q, rd_a_q};
    hist_wd   = 8'd0;
    hist_ra   = {in_word_i.read_slot[SW-1:0], pix_addr};
    ended_now = ended_q;

    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = 1'b1;
    do_apply   = 1'b0;
    load_res   = 1'b0;
    res_status = ST_OK;
    res_pixel  = 8'd0;

    new_img  = !active_q || (sel.image_number != cur_q);
    mask_new = (new_img ? '0 : mask_q) | (sel.part_end ? part_sel : '0);

    case (state_q)
      S_CLEAR: begin
        asm_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == PW'(FRAME_PIXELS - 1)) begin
          cnt_d   = '0;
          clean_d = 1'b1;
          pend_d  = 1'b0;
          state_d = pend_q ? S_APPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          item_d = in_word_i;
          if (in_word_i.operation == OP_READ) begin
            if (!dec.slot_ok) begin
              load_res   = 1'b1;
              res_status = ST_BAD_SLOT;
            end else if (!dec.in_frame) begin
              load_res = 1'b1;
            end else begin
              state_d = S_READ;
            end
          end else if (!dec.part_ok) begin
            load_res   = 1'b1;
            res_status = ST_BAD_PART;
          end else if (new_img && !clean_q) begin
            cur_d    = in_word_i.image_number;
            active_d = 1'b1;
            mask_d   = '0;
            pend_d   = 1'b1;
            cnt_d    = '0;
            state_d  = S_CLEAR;
          end else begin
            do_apply = 1'b1;
          end
        end
      end
      S_APPLY: begin
        do_apply = 1'b1;
      end
      S_READ: begin
        load_res  = 1'b1;
        res_pixel = hist_rd_q;
        state_d   = S_IDLE;
      end
      S_COMMIT: begin
        rd_v_d = 1'b1;
        rd_a_d = cnt_q;
        cnt_d  = cnt_q + 1'b1;
        if (rd_v_q) begin
          ended_now = ended_q || (asm_rd_q == 8'd0);
          ended_d   = ended_now;
          hist_we   = 1'b1;
          hist_wd   = ended_now ? 8'd0 : asm_rd_q - DIGIT_ZERO;
          asm_we    = 1'b1;
          asm_wa    = rd_a_q;
          if (rd_a_q == PW'(FRAME_PIXELS - 1)) begin
            rd_v_d     = 1'b0;
            cnt_d      = '0;
            wslot_d    = (32'(wslot_q) == HISTORY_DEPTH - 1) ? '0 : wslot_q + 1'b1;
            filled_d   = (32'(filled_q) < HISTORY_DEPTH) ? filled_q + 1'b1 : filled_q;
            mask_d     = '0;
            active_d   = 1'b0;
            clean_d    = 1'b1;
            load_res   = 1'b1;
            res_status = ST_DONE;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
        cnt_d   = '0;
      end
    endcase

    if (do_apply) begin
      cur_d    = sel.image_number;
      active_d = 1'b1;
      mask_d   = mask_new;
      if (dec.byte_ok) begin
        asm_we  = 1'b1;
        asm_wa  = store_addr;
        asm_wd  = sel.byte_value;
        clean_d = 1'b0;
      end
      if (sel.part_end && (&mask_new)) begin
        cnt_d   = '0;
        rd_v_d  = 1'b0;
        ended_d = 1'b0;
        state_d = S_COMMIT;
      end else begin
        load_res = 1'b1;
        state_d  = S_IDLE;
      end
    end

    if (load_res) begin
      out_valid_d         = 1'b1;
      out_d.status        = res_status;
      out_d.pixel_value   = res_pixel;
      out_d.frames_stored = 4'(filled_d);
      out_d.newest_slot   = 4'(wslot_d);
      out_d.parts_mask    = 8'(mask_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      rd_a_q      <= '0;
      ended_q     <= 1'b0;
      pend_q      <= 1'b0;
      mask_q      <= '0;
      cur_q       <= '0;
      active_q    <= 1'b0;
      clean_q     <= 1'b0;
      wslot_q     <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_v_q      <= rd_v_d;
      rd_a_q      <= rd_a_d;
      ended_q     <= ended_d;
      pend_q      <= pend_d;
      mask_q      <= mask_d;
      cur_q       <= cur_d;
      active_q    <= active_d;
      clean_q     <= clean_d;
      wslot_q     <= wslot_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `IPRH_NEVER(a_accept_only_idle, in_valid_i && !in_stall_o && state_q != S_IDLE)
  `IPRH_ASSERT(a_read_out_free, state_q == S_READ |-> !out_valid_q)
  `IPRH_ASSERT(a_apply_after_clear, state_q == S_APPLY |-> clean_q && active_q)
  `IPRH_ASSERT(a_ring_range, 32'(wslot_q) < HISTORY_DEPTH && 32'(filled_q) <= HISTORY_DEPTH)
  `IPRH_ASSERT(a_commit_end, state_q == S_COMMIT && state_d == S_IDLE |=> mask_q == '0 && !active_q && clean_q && out_valid_q)

endmodule

/* tb/sv/reassembly_checker.sv */
`timescale 1ns / 1ps
// Reply checker for the image part reassembly core: watches both word channels,
// predicts every reply from its own assembly buffer and frame history, and compares.
// Depends on iprh_pkg.
module reassembly_checker #(
  parameter int unsigned FRAME_PIXELS  = 1024,
  parameter int unsigned PART_COUNT    = 8,
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned FRAME_SIDE    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  iprh_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  iprh_pkg::out_word_t out_word_i,
  output int                  fail_count_o,
  output int                  due_count_o,
  output logic [3:0]          frames_held_o
);
  import iprh_pkg::*;

  localparam int unsigned PART_BYTES = FRAME_PIXELS / PART_COUNT;

  logic [7:0] asm_buf [FRAME_PIXELS];
  logic [7:0] history [HISTORY_DEPTH][FRAME_PIXELS];
  logic [PART_COUNT-1:0] got_parts;
  logic [15:0] cur_img;
  logic        img_open;
  logic [3:0]  next_slot;
  logic [3:0]  n_frames;
  out_word_t   due_replies [$];
  out_word_t   want;
  int          fails;
  int          due_n;

  assign fail_count_o  = fails;
  assign due_count_o   = due_n;
  assign frames_held_o = n_frames;

  function automatic void clear_assembly();
    for (int i = 0; i < FRAME_PIXELS; i++) asm_buf[i] = 8'd0;
    got_parts = '0;
  endfunction

  function automatic void store_frame();
    logic       ended;
    logic [7:0] c;
    ended = 1'b0;
    for (int i = 0; i < FRAME_PIXELS; i++) begin
      c = asm_buf[i];
      if (c == 8'd0) ended = 1'b1;
      history[next_slot][i] = ended ? 8'd0 : c - DIGIT_ZERO;
    end
    next_slot = (next_slot == HISTORY_DEPTH - 1) ? 4'd0 : next_slot + 4'd1;
    if (n_frames < HISTORY_DEPTH) n_frames = n_frames + 4'd1;
    clear_assembly();
    img_open = 1'b0;
  endfunction

  function automatic out_word_t reassemble_step(in_word_t w);
    out_word_t   r;
    int unsigned part;
    int unsigned pos;
    r = '0;
    part = 32'(w.part_index);
    if (w.operation == OP_WRITE) begin
      if (part == 0 || part > PART_COUNT) begin
        r.status = ST_BAD_PART;
      end else begin
        if (!img_open || w.image_number != cur_img) begin
          clear_assembly();
          cur_img = w.image_number;
          img_open = 1'b1;
        end
        pos = (part - 1) * PART_BYTES + 32'(w.byte_offset);
        if (w.byte_value != 8'd0 && w.byte_offset < PART_BYTES && pos < FRAME_PIXELS)
          asm_buf[pos] = w.byte_value;
        if (w.part_end) begin
          got_parts[part-1] = 1'b1;
          if (&got_parts) begin
            store_frame();
            r.status = ST_DONE;
          end
        end
      end
    end else if (w.read_slot >= HISTORY_DEPTH) begin
      r.status = ST_BAD_SLOT;
    end else if (w.read_row < FRAME_SIDE && w.read_col < FRAME_SIDE) begin
      pos = 32'(w.read_row) * FRAME_SIDE + 32'(w.read_col);
      if (pos < FRAME_PIXELS) r.pixel_value = history[w.read_slot][pos];
    end
    r.frames_stored = n_frames;
    r.newest_slot   = next_slot;
    r.parts_mask    = got_parts;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_assembly();
      cur_img = '0;
      img_open = 1'b0;
      next_slot = '0;
      n_frames = '0;
      due_replies.delete();
      fails = 0;
      due_n = 0;
    end else begin
      if (in_valid_i && !in_stall_i) due_replies.push_back(reassemble_step(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (due_replies.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected reply status %0d pixel %0d frames %0d slot %0d mask %02h",
                     $realtime, out_word_i.status, out_word_i.pixel_value,
                     out_word_i.frames_stored, out_word_i.newest_slot, out_word_i.parts_mask);
        end else begin
          want = due_replies.pop_front();
          if (out_word_i.status !== want.status || out_word_i.pixel_value !== want.pixel_value ||
              out_word_i.frames_stored !== want.frames_stored ||
              out_word_i.newest_slot !== want.newest_slot ||
              out_word_i.parts_mask !== want.parts_mask) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: reply mismatch, expected status %0d pixel %0d frames %0d slot %0d",
                        " mask %02h, got status %0d pixel %0d frames %0d slot %0d mask %02h"},
                       $realtime, want.status, want.pixel_value, want.frames_stored,
                       want.newest_slot, want.parts_mask, out_word_i.status,
                       out_word_i.pixel_value, out_word_i.frames_stored,
                       out_word_i.newest_slot, out_word_i.parts_mask);
          end
        end
      end
      due_n = due_replies.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the image part reassembly testbench: clock, reset, word stimulus, stalls and verdict.
// Depends on iprh_pkg, reassembly_checker and image_part_reassembly_with_history_core.
module tb;
  import iprh_pkg::*;

  localparam int unsigned FRAME_PIXELS  = 1024;
  localparam int unsigned PART_COUNT    = 8;
  localparam int unsigned HISTORY_DEPTH = 10;
  localparam int unsigned N_ITEMS       = 650;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_AT       = 200;
  localparam int unsigned PAUSE_AT      = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  int         fail_count;
  int         due_count;
  logic [3:0] frames_held;
  int         n_sent = 0;
  bit         holding = 1'b0;
  int         idle_cycles = 0;
  logic [15:0] last_img = '0;

  image_part_reassembly_with_history_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  reassembly_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .fail_count_o  (fail_count),
    .due_count_o   (due_count),
    .frames_held_o (frames_held)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic bit quiet();
    return n_sent >= N_ITEMS - 100 || (n_sent >= 300 && n_sent < 350);
  endfunction

  function automatic in_word_t any_word();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t write_word(logic [15:0] img, logic [3:0] part, logic [6:0] off,
                                          logic [7:0] val, logic last);
    in_word_t w;
    w = any_word();
    w.operation    = OP_WRITE;
    w.image_number = img;
    w.part_index   = part;
    w.byte_offset  = off;
    w.byte_value   = val;
    w.part_end     = last;
    return w;
  endfunction

  function automatic in_word_t read_word(logic [3:0] slot, logic [4:0] row, logic [4:0] col);
    in_word_t w;
    w = any_word();
    w.operation = OP_READ;
    w.read_slot = slot;
    w.read_row  = row;
    w.read_col  = col;
    return w;
  endfunction

  function automatic in_word_t pick_read();
    logic [3:0] slot;
    if (frames_held == 0 || $urandom_range(0, 5) == 0)
      slot = 4'($urandom_range(HISTORY_DEPTH, 15));
    else
      slot = 4'($urandom_range(0, frames_held - 1));
    if ($urandom_range(0, 1) == 0) return read_word(slot, 5'd0, 5'($urandom_range(0, 15)));
    return read_word(slot, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
  endfunction

  function automatic in_word_t bad_part_word();
    in_word_t w;
    w = any_word();
    w.operation  = OP_WRITE;
    w.part_index = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(PART_COUNT + 1, 15));
    return w;
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) != 0) return DIGIT_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_word(input in_word_t w);
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (n_sent == PAUSE_AT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (due_count != 0);
    end else if (!quiet() && !holding && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_image(input logic [15:0] img);
    int order [PART_COUNT];
    int tmp;
    int j;
    int nb;
    int cut;
    for (int i = 0; i < PART_COUNT; i++) order[i] = i + 1;
    for (int i = PART_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, PART_COUNT - 1) : PART_COUNT;
    for (int k = 0; k < cut; k++) begin
      nb = (order[k] == 1) ? $urandom_range(1, 10) : $urandom_range(1, 3);
      for (int b = 0; b < nb; b++) begin
        put_word(write_word(img, 4'(order[k]),
                            7'((order[k] == 1) ? b : $urandom_range(0, 127)),
                            pick_char(), b == nb - 1));
        if ($urandom_range(0, 19) == 0)
          put_word($urandom_range(0, 1) ? pick_read() : bad_part_word());
      end
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off to back the core up
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet() && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int kind;
    int n;
    wait (rst_n);
    @(posedge clk);

    put_word(read_word(4'd15, 5'd0, 5'd0));
    put_word(read_word(4'(HISTORY_DEPTH), 5'd31, 5'd31));
    put_word(write_word(16'h1234, 4'd0, 7'd0, 8'h35, 1'b1));
    put_word(write_word(16'h1234, 4'd9, 7'd5, 8'h31, 1'b1));
    put_word(write_word(16'h1234, 4'd15, 7'd127, 8'hFF, 1'b0));
    put_word(write_word(16'hFFFF, 4'd1, 7'd0, 8'h00, 1'b1));
    put_word(write_word(16'h0000, 4'd8, 7'd127, 8'hFF, 1'b0));
    put_word(write_word(16'h1234, 4'd1, 7'd0, DIGIT_ZERO + 8'd5, 1'b0));
    put_word(write_word(16'h1234, 4'd1, 7'd1, DIGIT_ZERO + 8'd9, 1'b0));
    put_word(write_word(16'h1234, 4'd1, 7'd2, 8'hFF, 1'b0));
    put_word(write_word(16'h1234, 4'd1, 7'd3, 8'h2F, 1'b1));
    for (int p = 2; p < PART_COUNT; p++)
      put_word(write_word(16'h1234, 4'(p), 7'($urandom_range(0, 127)), DIGIT_ZERO, 1'b1));
    put_word(write_word(16'h1234, 4'(PART_COUNT), 7'd127, 8'hFF, 1'b1));
    for (int c = 0; c < 5; c++) put_word(read_word(4'd0, 5'd0, 5'(c)));
    put_word(read_word(4'd0, 5'd31, 5'd31));

    while (n_sent < N_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        if ($urandom_range(0, 3) != 0) last_img = 16'($urandom_range(0, 65535));
        send_image(last_img);
      end else if (kind < 8) begin
        n = $urandom_range(1, 6);
        repeat (n) put_word(pick_read());
      end else if (kind == 8) begin
        put_word(bad_part_word());
      end else begin
        put_word(write_word(16'($urandom_range(0, 65535)), 4'($urandom_range(1, PART_COUNT)),
                            7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
      end
    end

    in_valid <= 1'b0;
    while (due_count != 0) @(posedge clk);
    repeat (FRAME_PIXELS + 16) @(posedge clk);
    if (fail_count == 0 && due_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
